FILE: hdl/bba_pkg.sv
// Package with the request and response types, status codes and defaults of the buddy allocator.
package bba_pkg;

    localparam int MAX_TREE_LEVELS_DEF = 8;
    localparam int SIZE_W              = 28;
    localparam int NODE_W              = 8;
    localparam int LEVEL_CNT_W         = 4;
    localparam int MIN_LOG2_W          = 5;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [LEVEL_CNT_W-1:0] LEVEL_COUNT_RST = 4'd8;
    localparam logic [MIN_LOG2_W-1:0]  MIN_LOG2_RST    = 5'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
    localparam logic [1:0] ST_BAD_NODE  = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [NODE_W-1:0] node_to_free;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] node_index;
        logic [SIZE_W-1:0] block_offset;
    } t_rsp;

endpackage

FILE: hdl/buddy_block_allocator.sv
// Top level of the buddy allocator: register port, request control and the free-bit memory.
// The free bits live in a single-port memory of 2**MAX_TREE_LEVELS-1 one-bit entries with a
// registered read. After reset a clearing pass writes every entry, leaving only the root free,
// before the first request is taken. An allocate, taken in the idle state, scans the levels
// node by node from the wanted level toward the root, reading and checking each node, and
// then splits one level at a time down to the wanted level. A free reads the buddy; while
// the buddy is free it merges and moves to the parent, setting the root when the merges reach
// it, and otherwise it marks its node free. A free of the root itself only sets the root. An
// oversized allocate or a bad node goes straight to the response. One request is in work at
// a time; a finished response waits in the output register while the next request is already
// taken, and while the output stays stalled the next request waits in its done state.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_TREE_LEVELS = MAX_TREE_LEVELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rsp                  o_out_data
);

    localparam int IW         = MAX_TREE_LEVELS;
    localparam int NODE_COUNT = (1 << MAX_TREE_LEVELS) - 1;
    localparam int LW         = $clog2(MAX_TREE_LEVELS + 1);
    localparam int KW         = 6;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_F_RD, S_F_CHK, S_F_CLR, S_F_SET, S_DONE
    } t_state;

    t_state                 r_state;
    logic [LEVEL_CNT_W-1:0] r_level_count;
    logic [MIN_LOG2_W-1:0]  r_min_log2;
    logic [IW-1:0]          r_idx;
    logic [LW-1:0]          r_lev;
    logic [LW-1:0]          r_want;
    logic [1:0]             r_status;
    logic                   r_free_op;
    logic                   r_out_valid;
    t_rsp                   r_out;

    logic                   mem [NODE_COUNT];
    logic                   r_rd;
    logic                   mem_we;
    logic                   mem_wd;
    logic [IW-1:0]          mem_idx;

    logic [LW-1:0]          lv;
    logic                   cfg_wr;
    logic                   in_acc;
    logic [4:0]             size_bits;
    logic [KW-1:0]          kmin;
    logic [IW:0]            lev_first;
    logic [IW:0]            next_first;
    logic                   lev_last;
    logic [IW-1:0]          mate;
    logic [IW-1:0]          parent;
    logic [IW-1:0]          left_child;
    logic [IW-1:0]          right_child;
    logic [16:0]            lv_limit;
    logic [IW+7:0]          free_ext;
    logic [IW+7:0]          node_ext;
    logic [IW+SIZE_W-1:0]   off_ext;
    logic [KW-1:0]          off_shift;

    always_comb begin
        if (r_level_count == '0) begin
            lv = LW'(1);
        end else if (5'(r_level_count) > 5'(MAX_TREE_LEVELS)) begin
            lv = LW'(MAX_TREE_LEVELS);
        end else begin
            lv = LW'(r_level_count);
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? APB_DATA_W'(r_min_log2) : APB_DATA_W'(r_level_count);

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        size_bits = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (((i_in_data.request_size - SIZE_W'(1)) >> b) != '0) begin
                size_bits = 5'(b + 1);
            end
        end
        if (i_in_data.request_size <= SIZE_W'(1)) begin
            size_bits = '0;
        end
        kmin = (KW'(size_bits) > KW'(r_min_log2)) ? KW'(size_bits) - KW'(r_min_log2) : '0;
    end

    assign lv_limit = (17'd1 << lv) - 17'd1;
    assign free_ext = {{IW{1'b0}}, i_in_data.node_to_free};

    assign lev_first   = ((IW + 1)'(1) << r_lev) - (IW + 1)'(1);
    assign next_first  = ((IW + 1)'(1) << (r_lev + LW'(1))) - (IW + 1)'(1);
    assign lev_last    = ({1'b0, r_idx} + (IW + 1)'(1)) == next_first;
    assign mate        = r_idx[0] ? r_idx + IW'(1) : r_idx - IW'(1);
    assign parent      = (r_idx - IW'(1)) >> 1;
    assign left_child  = IW'({r_idx, 1'b1});
    assign right_child = IW'({r_idx, 1'b0}) + IW'(2);

    assign node_ext  = {8'b0, r_idx};
    assign off_shift = KW'(r_min_log2) + KW'(lv) - KW'(1) - KW'(r_want);
    assign off_ext   = {{SIZE_W{1'b0}}, r_idx - IW'(lev_first)} << off_shift;

    always_comb begin
        mem_we  = 1'b0;
        mem_wd  = 1'b0;
        mem_idx = r_idx;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wd = (r_idx == '0);
            end
            S_A_CHK: begin
                mem_we = r_rd;
            end
            S_A_SPLIT: begin
                mem_we  = 1'b1;
                mem_wd  = 1'b1;
                mem_idx = right_child;
            end
            S_F_RD: begin
                mem_idx = mate;
            end
            S_F_CHK: begin
                mem_we  = 1'b1;
                mem_wd  = !r_rd;
                mem_idx = r_rd ? mate : r_idx;
            end
            S_F_CLR: begin
                mem_we = 1'b1;
            end
            S_F_SET: begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_idx] <= mem_wd;
        end
        r_rd <= mem[mem_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_idx         <= '0;
            r_level_count <= LEVEL_COUNT_RST;
            r_min_log2    <= MIN_LOG2_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_min_log2 <= pwdata[MIN_LOG2_W-1:0];
                end else begin
                    r_level_count <= pwdata[LEVEL_CNT_W-1:0];
                end
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(NODE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_free_op <= (i_in_data.opcode == OP_FREE);
                        if (i_in_data.opcode == OP_ALLOC) begin
                            if (kmin >= KW'(lv)) begin
                                r_status <= ST_TOO_LARGE;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_want   <= LW'(KW'(lv) - KW'(1) - kmin);
                                r_lev    <= LW'(KW'(lv) - KW'(1) - kmin);
                                r_idx    <= IW'(((IW + 1)'(1) << LW'(KW'(lv) - KW'(1) - kmin))
                                            - (IW + 1)'(1));
                                r_state  <= S_A_RD;
                            end
                        end else begin
                            r_idx <= free_ext[IW-1:0];
                            if (17'(i_in_data.node_to_free) >= lv_limit) begin
                                r_status <= ST_BAD_NODE;
                                r_state  <= S_DONE;
                            end else if (i_in_data.node_to_free == '0) begin
                                r_status <= ST_OK;
                                r_state  <= S_F_SET;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_F_RD;
                            end
                        end
                    end
                end
                S_A_RD: begin
                    r_state <= S_A_CHK;
                end
                S_A_CHK: begin
                    if (r_rd) begin
                        r_state <= (r_lev == r_want) ? S_DONE : S_A_SPLIT;
                    end else if (lev_last) begin
                        if (r_lev == '0) begin
                            r_status <= ST_NO_BLOCK;
                            r_state  <= S_DONE;
                        end else begin
                            r_lev   <= r_lev - LW'(1);
                            r_idx   <= IW'(((IW + 1)'(1) << (r_lev - LW'(1))) - (IW + 1)'(1));
                            r_state <= S_A_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_A_SPLIT: begin
                    r_idx <= left_child;
                    r_lev <= r_lev + LW'(1);
                    if (r_lev + LW'(1) == r_want) begin
                        r_state <= S_DONE;
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    r_state <= r_rd ? S_F_CLR : S_DONE;
                end
                S_F_CLR: begin
                    r_idx   <= parent;
                    r_state <= (parent == '0) ? S_F_SET : S_F_RD;
                end
                S_F_SET: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= r_status;
                        if (r_status == ST_OK && !r_free_op) begin
                            r_out.node_index   <= node_ext[7:0];
                            r_out.block_offset <= off_ext[SIZE_W-1:0];
                        end else begin
                            r_out.node_index   <= '0;
                            r_out.block_offset <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: dv/testbench.sv
// Testbench for the buddy allocator: predicts each response from a tree model and checks it.
module testbench;
    import bba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = (1 << MAX_TREE_LEVELS_DEF) - 1;
    localparam int CYCLE_LIMIT = 5000000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_data;

    buddy_block_allocator dut (.*);

    logic [NODES-1:0] tree_free;
    logic [LEVEL_CNT_W-1:0] cfg_levels;
    logic [MIN_LOG2_W-1:0] cfg_min_log2;
    t_rsp pending_rsp[$];
    int mismatch_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[buddy_block_allocator] ERROR");
            $finish;
        end
    end

    function automatic int used_levels();
        if (cfg_levels == 0) return 1;
        if (cfg_levels > MAX_TREE_LEVELS_DEF) return MAX_TREE_LEVELS_DEF;
        return cfg_levels;
    endfunction

    function automatic t_rsp predict_alloc_free(t_req req);
        t_rsp r;
        int lv, want, lev, found, n, i, mate, idx;
        logic [63:0] off;
        r = '0;
        lv = used_levels();
        want = -1;
        found = -1;
        if (req.opcode == OP_ALLOC) begin
            for (int k = 0; k < lv; k++) begin
                if (want < 0 && 64'(req.request_size) <= (64'd1 << (cfg_min_log2 + k)))
                    want = lv - 1 - k;
            end
            if (want < 0) begin
                r.status = ST_TOO_LARGE;
            end else begin
                for (lev = want; lev >= 0 && found < 0; lev--) begin
                    for (i = (1 << lev) - 1; i <= (1 << (lev + 1)) - 2 && found < 0; i++)
                        if (tree_free[i]) found = i;
                    if (found >= 0) break;
                end
                if (found < 0) begin
                    r.status = ST_NO_BLOCK;
                end else begin
                    n = found;
                    tree_free[n] = 1'b0;
                    while (lev < want) begin
                        tree_free[2 * n + 2] = 1'b1;
                        n = 2 * n + 1;
                        lev++;
                    end
                    r.node_index = n[NODE_W-1:0];
                    off = 64'(n - ((1 << want) - 1)) << (cfg_min_log2 + (lv - 1 - want));
                    r.block_offset = off[SIZE_W-1:0];
                end
            end
        end else begin
            idx = req.node_to_free;
            if (idx >= (1 << lv) - 1) begin
                r.status = ST_BAD_NODE;
            end else begin
                while (idx != 0) begin
                    mate = idx[0] ? idx + 1 : idx - 1;
                    if (mate < NODES && tree_free[mate]) begin
                        tree_free[mate] = 1'b0;
                        tree_free[idx] = 1'b0;
                        idx = (idx - 1) >> 1;
                    end else begin
                        tree_free[idx] = 1'b1;
                        break;
                    end
                end
                if (idx == 0) tree_free[0] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want_val);
        $display("mismatch %s: got %0d expected %0d", what, got, want_val);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_out_data.status !== exp_rsp.status)
                    report_mismatch("status", o_out_data.status, exp_rsp.status);
                if (o_out_data.node_index !== exp_rsp.node_index)
                    report_mismatch("node_index", o_out_data.node_index, exp_rsp.node_index);
                if (o_out_data.block_offset !== exp_rsp.block_offset)
                    report_mismatch("block_offset", o_out_data.block_offset,
                                    exp_rsp.block_offset);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_recv) begin
            hold_cycles <= 400;
            hold_recv <= 1'b0;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_request(t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        pending_rsp.push_back(predict_alloc_free(req));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(int index, logic [APB_DATA_W-1:0] value);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * index);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == 0) cfg_levels = value[LEVEL_CNT_W-1:0];
        else cfg_min_log2 = value[MIN_LOG2_W-1:0];
    endtask

    function automatic t_req make_alloc(logic [SIZE_W-1:0] sz);
        t_req r;
        r.opcode = OP_ALLOC;
        r.request_size = sz;
        r.node_to_free = NODE_W'($urandom);
        return r;
    endfunction

    function automatic t_req make_free(logic [NODE_W-1:0] nd);
        t_req r;
        r.opcode = OP_FREE;
        r.request_size = SIZE_W'($urandom);
        r.node_to_free = nd;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int s;
        s = $urandom_range(cfg_min_log2 + used_levels());
        case ($urandom_range(3))
            0: return SIZE_W'($urandom);
            1: return SIZE_W'(1) << (s > 27 ? 27 : s);
            default: return SIZE_W'($urandom) >> (27 - (s > 27 ? 27 : s));
        endcase
    endfunction

    task automatic test_directed();
        send_request(make_alloc('0));
        send_request(make_alloc({SIZE_W{1'b1}}));
        send_request(make_alloc(SIZE_W'(2048)));
        send_request(make_alloc(SIZE_W'(2049)));
        send_request(make_alloc(SIZE_W'(16)));
        send_request(make_alloc(SIZE_W'(17)));
        send_request(make_free(8'd254));
        send_request(make_free(8'd255));
        send_request(make_free(8'd127));
        send_request(make_free(8'd127));
        send_request(make_free(8'd0));
        send_request(make_alloc(SIZE_W'(2048)));
        send_request(make_alloc(SIZE_W'(2048)));
        send_request(make_free(8'd0));
        write_reg(0, 0);
        send_request(make_alloc(SIZE_W'(16)));
        send_request(make_free(8'd1));
        send_request(make_free(8'd0));
        write_reg(0, 15);
        write_reg(1, 20);
        send_request(make_alloc(SIZE_W'(1) << 27));
        send_request(make_alloc({SIZE_W{1'b1}}));
        send_request(make_free(8'd200));
        write_reg(1, 0);
        send_request(make_alloc(SIZE_W'(1)));
        send_request(make_alloc(SIZE_W'(2)));
        send_request(make_free(8'd128));
    endtask

    task automatic test_random(int count);
        logic [NODE_W-1:0] owned[$];
        int j;
        for (int n = 0; n < count; n++) begin
            if (owned.size() > 0 && $urandom_range(99) < 45) begin
                j = $urandom_range(owned.size() - 1);
                send_request(make_free(owned[j]));
                owned.delete(j);
            end else if ($urandom_range(99) < 8) begin
                send_request(make_free(NODE_W'($urandom)));
            end else begin
                send_request(make_alloc(random_size()));
                if (pending_rsp[$].status == ST_OK) owned.push_back(pending_rsp[$].node_index);
            end
        end
        foreach (owned[k]) send_request(make_free(owned[k]));
    endtask

    task automatic test_backpressure();
        hold_recv <= 1'b1;
        for (int n = 0; n < 20; n++) send_request(make_alloc(random_size()));
        wait_drained();
        for (int n = 0; n < 20; n++) send_request(make_free(NODE_W'($urandom_range(254))));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        cycle_count = 0;
        mismatch_count = 0;
        tree_free = '0;
        tree_free[0] = 1'b1;
        cfg_levels = LEVEL_COUNT_RST;
        cfg_min_log2 = MIN_LOG2_RST;
        send_idle_pct = 24;
        recv_idle_pct = 75;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_reg(0, 8);
        write_reg(1, 4);
        test_random(400);
        send_idle_pct = 75;
        recv_idle_pct = 24;
        write_reg(0, 3);
        write_reg(1, 7);
        test_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(0, 8);
        write_reg(1, 20);
        test_random(400);
        write_reg(0, 5);
        write_reg(1, 0);
        test_random(400);
        test_backpressure();
        wait_drained();
        if (mismatch_count == 0)
            $display("[buddy_block_allocator] OK");
        else
            $display("[buddy_block_allocator] ERROR");
        $finish;
    end
endmodule
